// File: rtl/pafe_pkg.sv
// ----------------------------------------------------------------------------
// pafe_pkg - shared types and constants for the partition block
// Transaction payloads, sequencer states and ALU width.
// ----------------------------------------------------------------------------
`default_nettype none

package pafe_pkg;

   localparam int DEPTH_DEFAULT = 32;
   localparam int DATA_W        = 16;
   localparam int ALU_W         = DATA_W + 1;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     is_final;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] out_value;
      logic                     out_final;
      logic                     overflow;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_LOW_RD,
      ST_LOW_OUT,
      ST_PIVOT,
      ST_HIGH_RD,
      ST_HIGH_OUT
   } pafe_state_type;

endpackage

`default_nettype wire

// File: rtl/pafe_alu.sv
// ----------------------------------------------------------------------------
// pafe_alu - shared subtract unit
// One signed subtractor: element compare while loading, counter steps
// while emitting.
// ----------------------------------------------------------------------------
`default_nettype none

module pafe_alu (
   input  wire logic signed [pafe_pkg::ALU_W-1:0] op_a,
   input  wire logic signed [pafe_pkg::ALU_W-1:0] op_b,
   output logic signed [pafe_pkg::ALU_W-1:0]      diff,
   output logic                                   le
);

   // operands are sign- or zero-extended 16-bit values: no overflow at 17 bits
   assign diff = op_a - op_b;
   assign le   = diff[pafe_pkg::ALU_W-1] | (diff == '0);

endmodule

`default_nettype wire

// File: rtl/pafe_store.sv
// ----------------------------------------------------------------------------
// pafe_store - element memory
// One write port, one read port with registered read data. Stack grows up
// from address zero, FIFO grows down from the top address.
// ----------------------------------------------------------------------------
`default_nettype none

module pafe_store #(
   parameter int DEPTH = pafe_pkg::DEPTH_DEFAULT,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic                               clock,
   input  wire logic                               wr_en,
   input  wire logic [AW-1:0]                      wr_addr,
   input  wire logic signed [pafe_pkg::DATA_W-1:0] wr_data,
   input  wire logic                               rd_en,
   input  wire logic [AW-1:0]                      rd_addr,
   output logic signed [pafe_pkg::DATA_W-1:0]      rd_data
);

   logic signed [pafe_pkg::DATA_W-1:0] mem [DEPTH];
   logic signed [pafe_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/partition_around_first_element_top.sv
// ----------------------------------------------------------------------------
// partition_around_first_element_top - partition a sequence around its head
// First element is the pivot; later elements <= pivot are stacked, greater
// ones queued. On the final element the run is emitted: stack (last pushed
// first), pivot, then queue in arrival order.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------
//  req     | in        | req_valid/req_stall | value, is_final
//  rsp     | out       | rsp_valid/rsp_stall | out_value, out_final, overflow
//
// Loading: an element is taken whenever req_valid is high. A run of
//   N = 1 + low + high results is held by rsp_stall: each stored element
//   needs a read on the single memory port, then a state with its
//   registered data on rsp.
// Reset: synchronous, active high; clears pivot, counters, flags and sequencer.
//   Memory contents are not cleared, only written entries are read.
// Stalls: req_stall is high during a whole run; a stalled rsp transaction
//   holds its payload until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module partition_around_first_element_top #(
   parameter int DEPTH = pafe_pkg::DEPTH_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire pafe_pkg::req_payload_type req_payload,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output pafe_pkg::rsp_payload_type      rsp_payload
);

   localparam int AW = $clog2(DEPTH);
   // counts never exceed DEPTH-1, so AW bits hold them
   localparam int CW = AW;
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
   localparam logic [CW:0]   FULL_SUM  = (CW + 1)'(DEPTH - 1);

   pafe_pkg::pafe_state_type state_ff, state_in;

   logic signed [pafe_pkg::DATA_W-1:0] pivot_ff, pivot_in;
   logic                               have_pivot_ff, have_pivot_in;
   logic [CW-1:0]                      low_cnt_ff, low_cnt_in;
   logic [CW-1:0]                      high_cnt_ff, high_cnt_in;
   logic [CW-1:0]                      high_ptr_ff, high_ptr_in;
   logic                               dropped_ff, dropped_in;

   logic req_take;
   logic rsp_take;
   logic full;

   // shared ALU
   logic signed [pafe_pkg::ALU_W-1:0] alu_a, alu_b, alu_diff;
   logic                              alu_le;

   // memory ports
   logic                               wr_en, rd_en;
   logic [AW-1:0]                      wr_addr, rd_addr;
   logic signed [pafe_pkg::DATA_W-1:0] rd_data;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;
   assign full     = ({1'b0, low_cnt_ff} + {1'b0, high_cnt_ff}) >= FULL_SUM;

   pafe_alu u_alu (
      .op_a (alu_a),
      .op_b (alu_b),
      .diff (alu_diff),
      .le   (alu_le)
   );

   pafe_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_payload.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ALU operand select: compare while loading, step counters while emitting
   always_comb begin
      case (state_ff)
         pafe_pkg::ST_LOAD: begin
            alu_a = pafe_pkg::ALU_W'(req_payload.value);
            alu_b = pafe_pkg::ALU_W'(pivot_ff);
         end
         pafe_pkg::ST_LOW_RD: begin
            alu_a = pafe_pkg::ALU_W'(low_cnt_ff);
            alu_b = pafe_pkg::ALU_W'(1);
         end
         pafe_pkg::ST_HIGH_RD: begin
            alu_a = pafe_pkg::ALU_W'(high_ptr_ff);
            alu_b = '1;             // minus one: increment
         end
         default: begin
            alu_a = '0;
            alu_b = '0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pafe_pkg::ST_LOAD: begin
            if (req_take && req_payload.is_final) begin
               state_in = pafe_pkg::ST_LOW_RD;
            end
         end
         pafe_pkg::ST_LOW_RD: begin
            state_in = (low_cnt_ff == '0) ? pafe_pkg::ST_PIVOT : pafe_pkg::ST_LOW_OUT;
         end
         pafe_pkg::ST_LOW_OUT: begin
            if (rsp_take) begin
               state_in = pafe_pkg::ST_LOW_RD;
            end
         end
         pafe_pkg::ST_PIVOT: begin
            if (rsp_take) begin
               state_in = (high_cnt_ff == '0) ? pafe_pkg::ST_LOAD : pafe_pkg::ST_HIGH_RD;
            end
         end
         pafe_pkg::ST_HIGH_RD: begin
            state_in = pafe_pkg::ST_HIGH_OUT;
         end
         pafe_pkg::ST_HIGH_OUT: begin
            if (rsp_take) begin
               state_in = (high_ptr_ff == high_cnt_ff) ? pafe_pkg::ST_LOAD
                                                        : pafe_pkg::ST_HIGH_RD;
            end
         end
         default: begin
            state_in = pafe_pkg::ST_LOAD;
         end
      endcase
   end

   // outputs and datapath updates
   always_comb begin
      req_stall     = 1'b1;
      rsp_valid     = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = low_cnt_ff;
      rd_en         = 1'b0;
      rd_addr       = LAST_ADDR - high_ptr_ff;
      pivot_in      = pivot_ff;
      have_pivot_in = have_pivot_ff;
      low_cnt_in    = low_cnt_ff;
      high_cnt_in   = high_cnt_ff;
      high_ptr_in   = high_ptr_ff;
      dropped_in    = dropped_ff;
      rsp_payload.out_value = rd_data;
      rsp_payload.out_final = 1'b0;
      rsp_payload.overflow  = dropped_ff;
      case (state_ff)
         pafe_pkg::ST_LOAD: begin
            req_stall = 1'b0;
            if (req_take) begin
               if (!have_pivot_ff) begin
                  pivot_in      = req_payload.value;
                  have_pivot_in = 1'b1;
               end else if (full) begin
                  dropped_in = 1'b1;
               end else if (alu_le) begin
                  wr_en      = 1'b1;
                  wr_addr    = low_cnt_ff;
                  low_cnt_in = low_cnt_ff + 1'b1;
               end else begin
                  wr_en       = 1'b1;
                  wr_addr     = LAST_ADDR - high_cnt_ff;
                  high_cnt_in = high_cnt_ff + 1'b1;
               end
            end
         end
         pafe_pkg::ST_LOW_RD: begin
            if (low_cnt_ff != '0) begin
               rd_en      = 1'b1;
               rd_addr    = alu_diff[AW-1:0];
               low_cnt_in = alu_diff[CW-1:0];
            end
         end
         pafe_pkg::ST_LOW_OUT: begin
            rsp_valid = 1'b1;
         end
         pafe_pkg::ST_PIVOT: begin
            rsp_valid             = 1'b1;
            rsp_payload.out_value = pivot_ff;
            rsp_payload.out_final = (high_cnt_ff == '0);
         end
         pafe_pkg::ST_HIGH_RD: begin
            rd_en       = 1'b1;
            rd_addr     = LAST_ADDR - high_ptr_ff;
            high_ptr_in = alu_diff[CW-1:0];
         end
         pafe_pkg::ST_HIGH_OUT: begin
            rsp_valid             = 1'b1;
            rsp_payload.out_final = (high_ptr_ff == high_cnt_ff);
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
      // end of run: back to an empty sequence
      if (rsp_take && rsp_payload.out_final) begin
         pivot_in      = '0;
         have_pivot_in = 1'b0;
         low_cnt_in    = '0;
         high_cnt_in   = '0;
         high_ptr_in   = '0;
         dropped_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pafe_pkg::ST_LOAD;
         pivot_ff      <= '0;
         have_pivot_ff <= 1'b0;
         low_cnt_ff    <= '0;
         high_cnt_ff   <= '0;
         high_ptr_ff   <= '0;
         dropped_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pivot_ff      <= pivot_in;
         have_pivot_ff <= have_pivot_in;
         low_cnt_ff    <= low_cnt_in;
         high_cnt_ff   <= high_cnt_in;
         high_ptr_ff   <= high_ptr_in;
         dropped_ff    <= dropped_in;
      end
   end

`ifndef SYNTH
   // never ready for a new element while a run is going out
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("req ready during emission");

   // pivot plus stored elements never exceed the store
   assert property (@(posedge clock) disable iff (reset)
      ({1'b0, low_cnt_ff} + {1'b0, high_cnt_ff}) <= FULL_SUM)
      else $error("store overfilled");

   // last result of a run leaves an empty sequence behind
   assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_payload.out_final) |=>
         (state_ff == pafe_pkg::ST_LOAD) && !have_pivot_ff &&
         (low_cnt_ff == '0) && (high_cnt_ff == '0) && !dropped_ff)
      else $error("state not cleared after run");

   // no element lands in the store without a pivot
   assert property (@(posedge clock) disable iff (reset)
      !have_pivot_ff |-> (low_cnt_ff == '0) && (high_cnt_ff == '0))
      else $error("elements stored before pivot");
`endif

endmodule

`default_nettype wire
